// ----- design/msmx_pkg.sv -----
// Package: widths, constants and the 2^-x table for the masked softmax unit.
package msmx_pkg;
   localparam int MaxActions = 16;
   localparam int IdxW = $clog2(MaxActions);
   localparam int CntW = $clog2(MaxActions + 1);
   localparam int TableDepth = 256;
   localparam int TabW = $clog2(TableDepth);
   localparam int ExpW = 17;
   localparam int SumW = 22;
   localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};
   localparam logic [16:0] Log2eQ16 = 17'd94548;

   function automatic logic [ExpW-1:0] pow2_entry(input int k);
      logic [63:0] y;
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      logic [63:0] r;
      y = (64'(k) * 64'd744261118 + 64'(TableDepth / 2)) / 64'(TableDepth);
      term = 64'd1073741824;
      pos = 64'd1073741824;
      neg = 64'd0;
      for (int n = 1; n <= 20; n++) begin
         term = ((term * y) >> 30) / 64'(n);
         if (n % 2 == 1) neg = neg + term;
         else pos = pos + term;
      end
      r = pos - neg;
      return ExpW'((r * 64'd65536 + (64'd1 << 29)) >> 30);
   endfunction

   typedef struct packed {
      logic none_avail;
      logic ovf;
   } flags_type;
endpackage

// ----- design/masked_softmax_with_temperature_unit.sv -----
// Loading accepts one item per cycle while req_ready is high; after a last item, the
// exponent pass steps through S_ERD, S_EMUL, S_ELOG and S_EWR for each action, and the
// normalize pass through S_NRD, S_NDIV, S_NWAIT (skipped when no action is available or
// the sum is zero; else it waits for the bit-serial divider, 33 steps) and S_OUT, which holds while rsp_ready is low.
// Items are taken one set at a time; req_ready is low while a set is processed.
// Synchronous reset clears count, maximum, sum and flags; the memories are not cleared.
module masked_softmax_with_temperature_unit (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [15:0] req_q_value,
   input  logic req_available,
   input  logic [15:0] req_inv_temp,
   input  logic req_last_action,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [15:0] rsp_probability,
   output logic [5:0] rsp_action_index,
   output logic rsp_last_prob,
   output logic rsp_none_available,
   output logic rsp_overflowed
);
   import msmx_pkg::*;

   typedef enum logic [3:0] {
      S_LOAD, S_ERD, S_EMUL, S_ELOG, S_EWR, S_NRD, S_NDIV, S_NWAIT, S_OUT
   } state_type;

   logic [16:0] act_mem [MaxActions];
   logic [ExpW-1:0] exp_mem [MaxActions];
   logic [ExpW-1:0] pow2_rom [TableDepth];
   logic [16:0] act_rd_ff;
   logic [ExpW-1:0] exp_rd_ff;

   state_type state_ff;
   logic [CntW-1:0] count_ff;
   logic [IdxW-1:0] ptr_ff;
   logic signed [15:0] max_ff;
   logic [SumW-1:0] sum_ff;
   logic [15:0] itemp_ff;
   flags_type flags_ff;
   logic any_ff;
   logic [31:0] x_ff;
   logic [48:0] t_ff;
   logic [15:0] prob_ff;
   logic [5:0] idx_ff;
   logic last_ff;

   logic div_start, div_done;
   logic [15:0] div_q;
   logic [15:0] d_val;
   logic [TabW-1:0] tab_idx;
   logic [ExpW-1:0] e_val;
   logic [SumW:0] sum_add;
   logic accept;

   for (genvar k = 0; k < TableDepth; k++) begin : g_rom
      assign pow2_rom[k] = pow2_entry(k);
   end

   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == S_LOAD);
   assign d_val = 16'(max_ff - $signed(act_rd_ff[15:0]));
   assign tab_idx = t_ff[15:16-TabW];
   assign e_val = (t_ff[48:16] >= 33'd17) ? '0 : (pow2_rom[tab_idx] >> t_ff[20:16]);
   assign sum_add = {1'b0, sum_ff} + (act_rd_ff[16] ? (SumW+1)'(e_val) : '0);
   assign div_start = (state_ff == S_NDIV) && any_ff && (sum_ff != '0);

   msmx_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .numer_e(exp_rd_ff), .denom(sum_ff), .done(div_done), .quot(div_q)
   );

   always_ff @(posedge clock) begin
      if (accept && count_ff < CntW'(MaxActions))
         act_mem[count_ff[IdxW-1:0]] <= {req_available, req_q_value};
      if (state_ff == S_EWR)
         exp_mem[ptr_ff] <= act_rd_ff[16] ? e_val : '0;
      act_rd_ff <= act_mem[ptr_ff];
      exp_rd_ff <= exp_mem[ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD; count_ff <= '0; ptr_ff <= '0;
         max_ff <= 16'sh8000; sum_ff <= '0; flags_ff <= '0; any_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_LOAD: if (accept) begin
               if (count_ff < CntW'(MaxActions)) begin
                  count_ff <= count_ff + 1'b1;
                  if (req_available) begin
                     any_ff <= 1'b1;
                     if (req_q_value > max_ff) max_ff <= req_q_value;
                  end
               end else flags_ff.ovf <= 1'b1;
               if (req_last_action) begin
                  itemp_ff <= req_inv_temp; ptr_ff <= '0; sum_ff <= '0;
                  state_ff <= S_ERD;
               end
            end
            S_ERD: state_ff <= S_EMUL;
            S_EMUL: begin
               x_ff <= d_val * itemp_ff; state_ff <= S_ELOG;
            end
            S_ELOG: begin
               t_ff <= 49'((x_ff * Log2eQ16) >> 16); state_ff <= S_EWR;
            end
            S_EWR: begin
               sum_ff <= sum_add[SumW] ? SumMax : sum_add[SumW-1:0];
               if (32'(ptr_ff) + 1 == 32'(count_ff)) begin
                  ptr_ff <= '0; state_ff <= S_NRD;
                  flags_ff.none_avail <= !any_ff;
               end else begin
                  ptr_ff <= ptr_ff + 1'b1; state_ff <= S_ERD;
               end
            end
            S_NRD: state_ff <= S_NDIV;
            S_NDIV: begin
               idx_ff <= 6'(ptr_ff);
               last_ff <= (32'(ptr_ff) + 1 == 32'(count_ff));
               if (!(any_ff && sum_ff != '0)) begin
                  prob_ff <= '0; state_ff <= S_OUT;
               end else state_ff <= S_NWAIT;
            end
            S_NWAIT: if (div_done) begin
               prob_ff <= div_q; state_ff <= S_OUT;
            end
            S_OUT: if (rsp_ready) begin
               if (last_ff) begin
                  state_ff <= S_LOAD; count_ff <= '0; ptr_ff <= '0;
                  max_ff <= 16'sh8000; sum_ff <= '0; flags_ff <= '0; any_ff <= 1'b0;
               end else begin
                  ptr_ff <= ptr_ff + 1'b1; state_ff <= S_NRD;
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_probability = prob_ff;
   assign rsp_action_index = idx_ff;
   assign rsp_last_prob = last_ff;
   assign rsp_none_available = flags_ff.none_avail;
   assign rsp_overflowed = flags_ff.ovf;
endmodule

// ----- design/msmx_divider.sv -----
// Restoring divider: quotient of (e*65536 + sum/2) / sum, one bit per cycle.
module msmx_divider (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [msmx_pkg::ExpW-1:0] numer_e,
   input  logic [msmx_pkg::SumW-1:0] denom,
   output logic done,
   output logic [15:0] quot
);
   import msmx_pkg::*;
   localparam int NumW = ExpW + 16;
   localparam int StepW = $clog2(NumW + 1);
   logic [NumW-1:0] num_ff, num_in;
   logic [SumW:0] rem_ff, rem_in;
   logic [NumW-1:0] q_ff, q_in;
   logic [SumW-1:0] den_ff, den_in;
   logic [StepW-1:0] step_ff, step_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [SumW:0] trial;
   logic [SumW+1:0] shifted;

   always_comb begin
      num_in = num_ff; rem_in = rem_ff; q_in = q_ff; den_in = den_ff;
      step_in = step_ff; busy_in = busy_ff; done_in = 1'b0;
      shifted = {rem_ff, num_ff[NumW-1]};
      trial = shifted[SumW:0] - {1'b0, den_ff};
      if (start) begin
         num_in = {numer_e, 16'd0} + NumW'(denom >> 1);
         rem_in = '0; q_in = '0; den_in = denom;
         step_in = StepW'(NumW); busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         if (shifted >= {2'b00, den_ff}) begin
            rem_in = trial;
            q_in = {q_ff[NumW-2:0], 1'b1};
         end else begin
            rem_in = shifted[SumW:0];
            q_in = {q_ff[NumW-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == StepW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; step_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; step_ff <= step_in;
      end
      num_ff <= num_in; rem_ff <= rem_in; q_ff <= q_in; den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = (q_ff > NumW'(65535)) ? 16'hFFFF : q_ff[15:0];
endmodule
